>>> sv/chunk_reassembly_nack_tracker_assert.svh
// Assertion macros shared by the chunk reassembly tracker.
`ifndef CHUNK_REASSEMBLY_NACK_TRACKER_ASSERT_SVH
`define CHUNK_REASSEMBLY_NACK_TRACKER_ASSERT_SVH

`define CRNT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define CRNT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define CRNT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/crnt_pkg.sv
// Package with the types and codes of the chunk reassembly tracker.
package crnt_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CLEAR,
    ST_DUPCHK,
    ST_ACCEPT,
    ST_TSLOT,
    ST_TRD,
    ST_TCHK
  } state_t;

  localparam logic [1:0] FN_HDR  = 2'd0;
  localparam logic [1:0] FN_DATA = 2'd1;
  localparam logic [1:0] FN_TICK = 2'd2;

  localparam logic [2:0] EV_STORED   = 3'd0;
  localparam logic [2:0] EV_CORRUPT  = 3'd1;
  localparam logic [2:0] EV_MISSING  = 3'd2;
  localparam logic [2:0] EV_COMPLETE = 3'd3;
  localparam logic [2:0] EV_DUP      = 3'd4;
  localparam logic [2:0] EV_RANGE    = 3'd5;
  localparam logic [2:0] EV_FULL     = 3'd6;

  localparam int MAX_RESULTS = 16;
  localparam int RES_W = 5;

endpackage

>>> sv/chunk_reassembly_nack_tracker.sv
// Top level of the chunk reassembly tracker with its received-chunk memory.
// Payload bytes are taken one per cycle while the input is not stalled. A header whose chunk is
// out of range is answered at once; otherwise the input is held while the header passes through
// LOOKUP (and only that when the table is full), then DUPCHK for a known file, and ACCEPT when
// the chunk is taken, since the received-chunk memory read is registered. A header that opens a
// new file slot first clears that slot's row of the memory in CLEAR, one entry a cycle, before
// ACCEPT. A tick spends a TSLOT step on each slot it visits and one more to finish, and a TRD
// and a TCHK step on each chunk flag it reads until it finds the first missing chunk.
// Every request is held off while the result register is full and stalled.
module chunk_reassembly_nack_tracker #(
  parameter int FILE_SLOTS      = 16,
  parameter int CHUNK_SLOTS     = 1024,
  parameter int MAX_CHUNK_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_file_id,
  input  logic [15:0] in_chunk_id,
  input  logic [15:0] in_total_chunks,
  input  logic [31:0] in_checksum,
  input  logic [13:0] in_length,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [15:0] out_result_file,
  output logic [15:0] out_result_chunk,
  output logic        out_last
);

  localparam int SW    = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int CW    = $clog2(CHUNK_SLOTS);
  localparam int TW    = $clog2(CHUNK_SLOTS + 1);
  localparam int UW    = $clog2(FILE_SLOTS + 1);
  localparam int LW    = $clog2(MAX_CHUNK_BYTES + 1);
  localparam int AW    = SW + CW;
  localparam int DEPTH = FILE_SLOTS << CW;

  crnt_pkg::state_t state_r, state_nxt;

  logic [UW-1:0] used_slots_r;
  logic [15:0]   ids_r  [FILE_SLOTS];
  logic [TW-1:0] tot_r  [FILE_SLOTS];
  logic          done_r [FILE_SLOTS];

  logic          pend_r;
  logic [SW-1:0] pslot_r;
  logic [CW-1:0] pchunk_r;
  logic [31:0]   exp_r;
  logic [LW-1:0] left_r;
  logic [7:0]    sum_r;

  logic [15:0]         hdr_file_r;
  logic [15:0]         hdr_chunk_r;
  logic [TW-1:0]       hdr_tot_r;
  logic [FILE_SLOTS-1:0] match_r;

  logic [TW-1:0]             cnt_r;
  logic [UW-1:0]             s_r;
  logic [crnt_pkg::RES_W-1:0] nres_r;

  logic          mem [DEPTH];
  logic          rdata_r;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic          wdata;
  logic [AW-1:0] rd_addr;

  logic          out_valid_r;
  logic [2:0]    out_ev_r;
  logic [15:0]   out_file_r;
  logic [15:0]   out_chunk_r;
  logic          out_last_r;

  logic          can_emit, in_fire, emit;
  logic [2:0]    ev;
  logic [15:0]   efile, echunk;
  logic          elast;
  logic [FILE_SLOTS-1:0] used_mask, elig;
  logic          found, full, later, scan_done, cid_range, fin_ok, t_complete;
  logic [SW-1:0] found_idx, sidx;
  logic [7:0]    sum_after;
  logic [LW-1:0] len_clamp;
  logic [TW-1:0] tot_sat;

  assign can_emit  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != crnt_pkg::ST_IDLE) || !can_emit;
  assign in_fire   = in_valid && !in_stall;
  assign sum_after = sum_r + in_data_byte;
  assign cid_range = {16'd0, in_chunk_id} >= 32'(CHUNK_SLOTS);
  assign len_clamp = ({18'd0, in_length} > 32'(MAX_CHUNK_BYTES)) ?
                     LW'(MAX_CHUNK_BYTES) : LW'(in_length);
  assign tot_sat   = ({16'd0, in_total_chunks} > 32'(CHUNK_SLOTS)) ?
                     TW'(CHUNK_SLOTS) : TW'(in_total_chunks);
  assign full      = used_slots_r == UW'(FILE_SLOTS);
  assign sidx      = s_r[SW-1:0];
  assign scan_done = (s_r >= used_slots_r) ||
                     (nres_r == crnt_pkg::RES_W'(crnt_pkg::MAX_RESULTS));
  assign t_complete = (cnt_r + TW'(1)) == tot_r[sidx];

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    later     = 1'b0;
    for (int i = FILE_SLOTS - 1; i >= 0; i--) begin
      used_mask[i] = UW'(i) < used_slots_r;
      elig[i]      = used_mask[i] && (tot_r[i] != '0) && !done_r[i];
      if (match_r[i]) begin
        found     = 1'b1;
        found_idx = SW'(i);
      end
      if ((UW'(i) > s_r) && elig[i]) begin
        later = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crnt_pkg::ST_IDLE: begin
        if (in_fire && in_func == crnt_pkg::FN_HDR && !cid_range) begin
          state_nxt = crnt_pkg::ST_LOOKUP;
        end else if (in_fire && in_func == crnt_pkg::FN_TICK) begin
          state_nxt = crnt_pkg::ST_TSLOT;
        end
      end
      crnt_pkg::ST_LOOKUP: begin
        if (found) begin
          state_nxt = crnt_pkg::ST_DUPCHK;
        end else if (!full) begin
          state_nxt = crnt_pkg::ST_CLEAR;
        end else if (can_emit) begin
          state_nxt = crnt_pkg::ST_IDLE;
        end
      end
      crnt_pkg::ST_CLEAR: begin
        if (cnt_r == TW'(CHUNK_SLOTS - 1)) begin
          state_nxt = crnt_pkg::ST_ACCEPT;
        end
      end
      crnt_pkg::ST_DUPCHK: begin
        if (!rdata_r) begin
          state_nxt = crnt_pkg::ST_ACCEPT;
        end else if (can_emit) begin
          state_nxt = crnt_pkg::ST_IDLE;
        end
      end
      crnt_pkg::ST_ACCEPT: begin
        if (left_r != '0 || can_emit) begin
          state_nxt = crnt_pkg::ST_IDLE;
        end
      end
      crnt_pkg::ST_TSLOT: begin
        if (scan_done) begin
          state_nxt = crnt_pkg::ST_IDLE;
        end else if (elig[sidx]) begin
          state_nxt = crnt_pkg::ST_TRD;
        end
      end
      crnt_pkg::ST_TRD: begin
        state_nxt = crnt_pkg::ST_TCHK;
      end
      crnt_pkg::ST_TCHK: begin
        if (!rdata_r || t_complete) begin
          if (can_emit) begin
            state_nxt = crnt_pkg::ST_TSLOT;
          end
        end else begin
          state_nxt = crnt_pkg::ST_TRD;
        end
      end
      default: state_nxt = crnt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    emit    = 1'b0;
    ev      = crnt_pkg::EV_STORED;
    efile   = hdr_file_r;
    echunk  = hdr_chunk_r;
    elast   = 1'b1;
    mem_we  = 1'b0;
    waddr   = {pslot_r, pchunk_r};
    wdata   = 1'b1;
    rd_addr = {found_idx, hdr_chunk_r[CW-1:0]};
    fin_ok  = 1'b0;
    unique case (state_r)
      crnt_pkg::ST_IDLE: begin
        if (in_fire && in_func == crnt_pkg::FN_HDR && cid_range) begin
          emit   = 1'b1;
          ev     = crnt_pkg::EV_RANGE;
          efile  = in_file_id;
          echunk = in_chunk_id;
        end else if (in_fire && in_func == crnt_pkg::FN_DATA && left_r == LW'(1) && pend_r) begin
          fin_ok = {24'd0, sum_after} == exp_r;
          emit   = 1'b1;
          ev     = fin_ok ? crnt_pkg::EV_STORED : crnt_pkg::EV_CORRUPT;
          efile  = ids_r[pslot_r];
          echunk = 16'(pchunk_r);
          mem_we = fin_ok;
        end
      end
      crnt_pkg::ST_LOOKUP: begin
        if (!found && full && can_emit) begin
          emit = 1'b1;
          ev   = crnt_pkg::EV_FULL;
        end
      end
      crnt_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = {pslot_r, cnt_r[CW-1:0]};
        wdata  = 1'b0;
      end
      crnt_pkg::ST_DUPCHK: begin
        if (rdata_r && can_emit) begin
          emit = 1'b1;
          ev   = crnt_pkg::EV_DUP;
        end
      end
      crnt_pkg::ST_ACCEPT: begin
        if (left_r == '0 && can_emit) begin
          fin_ok = exp_r == 32'd0;
          emit   = 1'b1;
          ev     = fin_ok ? crnt_pkg::EV_STORED : crnt_pkg::EV_CORRUPT;
          efile  = ids_r[pslot_r];
          echunk = 16'(pchunk_r);
          mem_we = fin_ok;
        end
      end
      crnt_pkg::ST_TSLOT: begin
        rd_addr = {sidx, cnt_r[CW-1:0]};
      end
      crnt_pkg::ST_TRD, crnt_pkg::ST_TCHK: begin
        rd_addr = {sidx, cnt_r[CW-1:0]};
        elast   = (nres_r == crnt_pkg::RES_W'(crnt_pkg::MAX_RESULTS - 1)) || !later;
        efile   = ids_r[sidx];
        if (state_r == crnt_pkg::ST_TCHK && can_emit && (!rdata_r || t_complete)) begin
          emit   = 1'b1;
          ev     = rdata_r ? crnt_pkg::EV_COMPLETE : crnt_pkg::EV_MISSING;
          echunk = rdata_r ? 16'd0 : 16'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= crnt_pkg::ST_IDLE;
      used_slots_r <= '0;
      pend_r       <= 1'b0;
      left_r       <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        crnt_pkg::ST_IDLE: begin
          if (in_fire && in_func == crnt_pkg::FN_HDR) begin
            pend_r <= 1'b0;
            left_r <= len_clamp;
            sum_r  <= '0;
          end else if (in_fire && in_func == crnt_pkg::FN_DATA && left_r != '0) begin
            sum_r  <= sum_after;
            left_r <= left_r - LW'(1);
            if (left_r == LW'(1)) begin
              pend_r <= 1'b0;
            end
          end
        end
        crnt_pkg::ST_LOOKUP: begin
          if (!found && !full) begin
            used_slots_r <= used_slots_r + UW'(1);
          end
        end
        crnt_pkg::ST_ACCEPT: begin
          if (left_r != '0) begin
            pend_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ev_r    <= ev;
      out_file_r  <= efile;
      out_chunk_r <= echunk;
      out_last_r  <= elast;
    end
    unique case (state_r)
      crnt_pkg::ST_IDLE: begin
        if (in_fire && in_func == crnt_pkg::FN_HDR) begin
          hdr_file_r  <= in_file_id;
          hdr_chunk_r <= in_chunk_id;
          hdr_tot_r   <= tot_sat;
          exp_r       <= in_checksum;
          pchunk_r    <= in_chunk_id[CW-1:0];
          for (int i = 0; i < FILE_SLOTS; i++) begin
            match_r[i] <= used_mask[i] && (ids_r[i] == in_file_id);
          end
        end
        if (in_fire && in_func == crnt_pkg::FN_TICK) begin
          s_r    <= '0;
          nres_r <= '0;
        end
      end
      crnt_pkg::ST_LOOKUP: begin
        if (found) begin
          pslot_r <= found_idx;
          if (tot_r[found_idx] == '0) begin
            tot_r[found_idx] <= hdr_tot_r;
          end
        end else if (!full) begin
          pslot_r                     <= used_slots_r[SW-1:0];
          ids_r[used_slots_r[SW-1:0]]  <= hdr_file_r;
          tot_r[used_slots_r[SW-1:0]]  <= hdr_tot_r;
          done_r[used_slots_r[SW-1:0]] <= 1'b0;
          cnt_r                       <= '0;
        end
      end
      crnt_pkg::ST_CLEAR: begin
        cnt_r <= cnt_r + TW'(1);
      end
      crnt_pkg::ST_TSLOT: begin
        if (!scan_done) begin
          if (elig[sidx]) begin
            cnt_r <= '0;
          end else begin
            s_r <= s_r + UW'(1);
          end
        end
      end
      crnt_pkg::ST_TCHK: begin
        if (emit) begin
          s_r    <= s_r + UW'(1);
          nres_r <= nres_r + crnt_pkg::RES_W'(1);
          if (rdata_r) begin
            done_r[sidx] <= 1'b1;
          end
        end else if (rdata_r && !t_complete) begin
          cnt_r <= cnt_r + TW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_ev_r;
  assign out_result_file  = out_file_r;
  assign out_result_chunk = out_chunk_r;
  assign out_last         = out_last_r;

`include "chunk_reassembly_nack_tracker_assert.svh"

  `CRNT_ASSERT_ALWAYS(a_used_bound, used_slots_r <= UW'(FILE_SLOTS), "Slot count overflow.")
  `CRNT_ASSERT_IMPLY(a_emit_room, emit, !(out_valid_r && out_stall), "Result register overrun.")
  `CRNT_ASSERT_IMPLY(a_pend_left, state_r == crnt_pkg::ST_IDLE && pend_r, left_r != '0,
                     "Pending chunk without payload bytes left.")
  `CRNT_ASSERT_NEXT(a_clear_end, state_r == crnt_pkg::ST_CLEAR && cnt_r == TW'(CHUNK_SLOTS - 1),
                    state_r == crnt_pkg::ST_ACCEPT, "Row clear did not end in accept.")

endmodule

>>> tb/sv/chunk_reassembly_nack_tracker_test.sv
// Testbench for the chunk reassembly tracker, predicting every event and checking it in order.
module chunk_reassembly_nack_tracker_test;

  localparam int SLOTS = 16;
  localparam int CHUNKS = 1024;
  localparam int MAX_BYTES = 8192;
  localparam int IDLE_LIMIT = 150000;
  localparam int HOLD_LEN = 300;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]  ev;
    logic [15:0] file;
    logic [15:0] chunk;
    logic        last;
  } event_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [15:0] in_file_id;
  logic [15:0] in_chunk_id;
  logic [15:0] in_total_chunks;
  logic [31:0] in_checksum;
  logic [13:0] in_length;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_event_res;
  logic [15:0] out_result_file;
  logic [15:0] out_result_chunk;
  logic        out_last;

  chunk_reassembly_nack_tracker DUT (.*);

  // Predicted state of the tracker.
  logic [15:0] slot_file[SLOTS];
  int          slot_total[SLOTS];
  bit          slot_finished[SLOTS];
  int          open_slots;
  bit          received[SLOTS][CHUNKS];
  bit          chunk_pending;
  int          pending_slot_no;
  int          pending_chunk_no;
  logic [31:0] wanted_sum;
  int          bytes_to_come;
  logic [7:0]  byte_sum;

  event_t awaited_events[$];
  event_t new_events[$];
  int     errors = 0;
  int     sender_idle_pct = 0;
  int     receiver_stall_pct = 0;
  int     hold_requests = 0;
  int     hold_taken = 0;
  int     hold_cycles = 0;
  int     idle_count = 0;
  int     counted_items = 0;
  logic [15:0] file_pool[10];
  int          pool_total[10];

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void add_event(logic [2:0] ev, logic [15:0] file, logic [15:0] chunk);
    event_t e;
    e.ev = ev;
    e.file = file;
    e.chunk = chunk;
    e.last = 1'b0;
    new_events.push_back(e);
  endfunction

  function automatic void close_chunk();
    chunk_pending = 1'b0;
    if ({24'd0, byte_sum} == wanted_sum) begin
      received[pending_slot_no][pending_chunk_no] = 1'b1;
      add_event(crnt_pkg::EV_STORED, slot_file[pending_slot_no], 16'(pending_chunk_no));
    end else begin
      add_event(crnt_pkg::EV_CORRUPT, slot_file[pending_slot_no], 16'(pending_chunk_no));
    end
  endfunction

  function automatic void track_header(logic [15:0] fid, logic [15:0] cid, logic [15:0] tot,
                                       logic [31:0] csum, logic [13:0] len);
    int s;
    bit found;
    s = 0;
    found = 0;
    chunk_pending = 1'b0;
    bytes_to_come = (len > MAX_BYTES) ? MAX_BYTES : len;
    byte_sum = 8'd0;
    if (cid >= CHUNKS) begin
      add_event(crnt_pkg::EV_RANGE, fid, cid);
      return;
    end
    for (int i = 0; i < open_slots; i++) begin
      if (!found && slot_file[i] == fid) begin
        found = 1;
        s = i;
      end
    end
    if (!found) begin
      if (open_slots >= SLOTS) begin
        add_event(crnt_pkg::EV_FULL, fid, cid);
        return;
      end
      s = open_slots++;
      slot_file[s] = fid;
      slot_total[s] = 0;
      slot_finished[s] = 1'b0;
      for (int c = 0; c < CHUNKS; c++) received[s][c] = 1'b0;
    end
    if (slot_total[s] == 0) slot_total[s] = (tot > CHUNKS) ? CHUNKS : tot;
    if (received[s][cid]) begin
      add_event(crnt_pkg::EV_DUP, fid, cid);
      return;
    end
    chunk_pending = 1'b1;
    pending_slot_no = s;
    pending_chunk_no = cid;
    wanted_sum = csum;
    if (bytes_to_come == 0) close_chunk();
  endfunction

  function automatic void track_tick();
    bit missing;
    for (int s = 0; s < open_slots && new_events.size() < crnt_pkg::MAX_RESULTS; s++) begin
      if (slot_total[s] != 0 && !slot_finished[s]) begin
        missing = 0;
        for (int c = 0; c < slot_total[s] && !missing; c++) begin
          if (!received[s][c]) begin
            add_event(crnt_pkg::EV_MISSING, slot_file[s], 16'(c));
            missing = 1;
          end
        end
        if (!missing) begin
          slot_finished[s] = 1'b1;
          add_event(crnt_pkg::EV_COMPLETE, slot_file[s], 16'd0);
        end
      end
    end
  endfunction

  function automatic void track_request(logic [1:0] func, logic [15:0] fid, logic [15:0] cid,
                                        logic [15:0] tot, logic [31:0] csum, logic [13:0] len,
                                        logic [7:0] data);
    new_events.delete();
    if (func == crnt_pkg::FN_HDR) begin
      track_header(fid, cid, tot, csum, len);
    end else if (func == crnt_pkg::FN_DATA) begin
      if (bytes_to_come != 0) begin
        byte_sum = byte_sum + data;
        bytes_to_come--;
        if (bytes_to_come == 0 && chunk_pending) close_chunk();
      end
    end else if (func == crnt_pkg::FN_TICK) begin
      track_tick();
    end
    if (new_events.size() > 0) new_events[new_events.size() - 1].last = 1'b1;
    foreach (new_events[i]) awaited_events.push_back(new_events[i]);
  endfunction

  task automatic send_request(logic [1:0] func, logic [15:0] fid, logic [15:0] cid,
                              logic [15:0] tot, logic [31:0] csum, logic [13:0] len,
                              logic [7:0] data);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 6) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_file_id <= fid;
    in_chunk_id <= cid;
    in_total_chunks <= tot;
    in_checksum <= csum;
    in_length <= len;
    in_data_byte <= data;
    do @(posedge clk); while (in_stall);
    track_request(func, fid, cid, tot, csum, len, data);
    if (func != FN_UNUSED) counted_items++;
  endtask

  task automatic send_header(logic [15:0] fid, logic [15:0] cid, logic [15:0] tot,
                             logic [31:0] csum, logic [13:0] len);
    send_request(crnt_pkg::FN_HDR, fid, cid, tot, csum, len, 8'($urandom));
  endtask

  task automatic send_data(logic [7:0] data);
    send_request(crnt_pkg::FN_DATA, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                 14'($urandom), data);
  endtask

  task automatic send_tick();
    send_request(crnt_pkg::FN_TICK, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                 14'($urandom), 8'($urandom));
  endtask

  // A whole chunk: header and payload, with a matching checksum unless spoilt.
  task automatic send_chunk(logic [15:0] fid, logic [15:0] cid, logic [15:0] tot, int len,
                            bit spoil);
    logic [7:0] payload[$];
    logic [7:0] total_sum;
    logic [31:0] csum;
    total_sum = 8'd0;
    for (int i = 0; i < len; i++) begin
      payload.push_back(8'($urandom));
      total_sum += payload[i];
    end
    csum = spoil ? $urandom : {24'd0, total_sum};
    send_header(fid, cid, tot, csum, 14'(len));
    foreach (payload[i]) send_data(payload[i]);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (awaited_events.size() != 0 || hold_cycles != 0 || hold_taken != hold_requests)
      @(posedge clk);
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_tick();
    send_header(16'hFFFF, 16'd0, 16'd3, 32'd0, 14'd2);
    send_data(8'hFF);
    send_data(8'h01);
    send_header(16'hFFFF, 16'd1, 16'd0, 32'd0, 14'd0);
    send_header(16'hFFFF, 16'd1, 16'd3, 32'd0, 14'd1);
    send_data(8'h55);
    send_header(16'hFFFF, 16'hFFFF, 16'd3, 32'd0, 14'd2);
    send_data(8'h00);
    send_data(8'h00);
    send_header(16'hFFFF, 16'd2, 16'd3, 32'h100, 14'd1);
    send_data(8'h00);
    send_tick();
    send_header(16'hFFFF, 16'd2, 16'd3, 32'd0, 14'd0);
    send_tick();
    send_tick();
    send_data(8'hAA);
    send_request(FN_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 14'h3FFF, 8'hFF);
    send_header(16'h0000, 16'd1023, 16'hFFFF, 32'hFFFFFFFF, 14'h3FFF);
    send_header(16'h0000, 16'd5, 16'd0, 32'd0, 14'd3);
    send_header(16'h0001, 16'd0, 16'd0, 32'd0, 14'd0);
    send_tick();
    wait_drain();
  endtask

  task automatic random_phase(int items, int idle_pct, int stall_pct);
    int stop;
    int k;
    int pick;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    stop = counted_items + items;
    while (counted_items < stop) begin
      pick = $urandom_range(99);
      k = $urandom_range(9);
      if (pick < 65) begin
        send_chunk(file_pool[k], 16'($urandom_range(pool_total[k])),
                   ($urandom_range(9) == 0) ? 16'($urandom) : 16'(pool_total[k]),
                   $urandom_range(4), $urandom_range(4) == 0);
      end else if (pick < 77) begin
        send_tick();
      end else if (pick < 83) begin
        send_header(file_pool[k], 16'($urandom_range(65535, CHUNKS)), 16'($urandom), $urandom,
                    14'($urandom_range(2)));
      end else if (pick < 90) begin
        // Broken chunk: the next header cuts its payload short.
        send_header(file_pool[k], 16'($urandom_range(pool_total[k])), 16'(pool_total[k]),
                    $urandom, 14'($urandom_range(16383, 3)));
        send_data(8'($urandom));
      end else if (pick < 96) begin
        send_data(8'($urandom));
      end else begin
        send_request(FN_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                     14'($urandom), 8'($urandom));
      end
    end
    wait_drain();
  endtask

  task automatic test_random();
    foreach (file_pool[i]) begin
      file_pool[i] = 16'($urandom);
      pool_total[i] = $urandom_range(4, 1);
    end
    random_phase(17, 0, 0);
    random_phase(17, 53, 0);
    random_phase(17, 0, 53);
    random_phase(17, 23, 23);
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_requests++;
    for (int i = 0; i < 20; i++) send_header(file_pool[i % 10], 16'(i), 16'd4, 32'd0, 14'd0);
    wait_drain();
  endtask

  task automatic test_table_full();
    sender_idle_pct = 23;
    receiver_stall_pct = 23;
    for (int i = 0; i < 8; i++) send_header(16'($urandom), 16'd0, 16'd2, 32'd1, 14'd0);
    send_chunk(16'($urandom), 16'd0, 16'd2, 2, 0);
    send_tick();
    wait_drain();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_taken != hold_requests) begin
      hold_taken <= hold_requests;
      hold_cycles <= HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  task automatic report_mismatch(string what);
    $display("Mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    event_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event %0d file %h chunk %0d",
                                  out_event_res, out_result_file, out_result_chunk));
      end else begin
        e = awaited_events.pop_front();
        if (out_event_res !== e.ev)
          report_mismatch($sformatf("event %0d, expected %0d", out_event_res, e.ev));
        if (out_result_file !== e.file)
          report_mismatch($sformatf("file %h, expected %h", out_result_file, e.file));
        if (out_result_chunk !== e.chunk)
          report_mismatch($sformatf("chunk %0d, expected %0d", out_result_chunk, e.chunk));
        if (out_last !== e.last)
          report_mismatch($sformatf("last %b, expected %b", out_last, e.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= crnt_pkg::FN_TICK;
    in_file_id <= '0;
    in_chunk_id <= '0;
    in_total_chunks <= '0;
    in_checksum <= '0;
    in_length <= '0;
    in_data_byte <= '0;
    open_slots = 0;
    chunk_pending = 1'b0;
    pending_slot_no = 0;
    pending_chunk_no = 0;
    wanted_sum = '0;
    bytes_to_come = 0;
    byte_sum = '0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_total[s] = 0;
      slot_finished[s] = 1'b0;
      for (int c = 0; c < CHUNKS; c++) received[s][c] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_table_full();
    repeat (2500) @(posedge clk);
    if (errors == 0 && awaited_events.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> chunk_reassembly_nack_tracker.f
+incdir+sv
sv/crnt_pkg.sv
sv/chunk_reassembly_nack_tracker.sv
tb/sv/chunk_reassembly_nack_tracker_test.sv
